// ----- src/hdspi_pkg.sv -----
// package for the half-duplex spi master: request codes, phase codes, widths
// no dependencies
`default_nettype none
package hdspi_pkg;
   localparam int DATA_WORDS_DEF = 8;
   localparam int CS_LINES_DEF   = 2;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 12;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;
   localparam logic [1:0] REQ_TICK  = 2'd3;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_CMD  = 2'd1;
   localparam logic [1:0] PH_MOSI = 2'd2;
   localparam logic [1:0] PH_MISO = 2'd3;

   localparam logic [2:0] CSR_CLK_DIV  = 3'd0;
   localparam logic [2:0] CSR_CPOL     = 3'd1;
   localparam logic [2:0] CSR_CPHA     = 3'd2;
   localparam logic [2:0] CSR_LSB      = 3'd3;
   localparam logic [2:0] CSR_CS       = 3'd4;
   localparam logic [2:0] CSR_CMD_BITS = 3'd5;
   localparam logic [2:0] CSR_MOSI_BITS = 3'd6;
   localparam logic [2:0] CSR_MISO_BITS = 3'd7;
endpackage
`default_nettype wire

// ----- src/half_duplex_spi_master.sv -----
// half-duplex spi master top level: csr registers, buffer, serial engine
// depends on hdspi_pkg
//
// channel | dir | transfer when
// req_    | in  | req_tvalid && req_tready
// rsp_    | out | rsp_tvalid && rsp_tready
// csr_    | in  | csr_we
//
// one item per cycle while req_tready is high; a result register with a skid slot parts the sides,
// so req_tready stays high unless both slots are full
// synchronous active-high reset clears control state; the data buffer is not reset
`default_nettype none
module half_duplex_spi_master #(
   parameter int DATA_WORDS = hdspi_pkg::DATA_WORDS_DEF,
   parameter int CS_LINES   = hdspi_pkg::CS_LINES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // word_index, write_data, miso_in, zero fill
   input  wire logic [1:0]  req_tuser,  // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // read_data, busy_res, rejected, sclk_out, mosi_out,
                                        // cs_lines_n, zero fill
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_wdata
);
   localparam int LIM = DATA_WORDS * 32;
   localparam int BW  = $clog2(LIM + 1) > 9 ? $clog2(LIM + 1) : 9;
   localparam int WW  = DATA_WORDS > 1 ? $clog2(DATA_WORDS) : 1;

   logic [11:0] clk_div_ff;
   logic        cpol_ff, cpha_ff, lsb_ff;
   logic [1:0]  cs_ff;
   logic [5:0]  cmd_bits_ff;
   logic [8:0]  mosi_bits_ff, miso_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_div_ff <= '0; cpol_ff <= 1'b0; cpha_ff <= 1'b0; lsb_ff <= 1'b0;
         cs_ff <= '0; cmd_bits_ff <= '0; mosi_bits_ff <= '0; miso_bits_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            hdspi_pkg::CSR_CLK_DIV:   clk_div_ff   <= csr_wdata;
            hdspi_pkg::CSR_CPOL:      cpol_ff      <= csr_wdata[0];
            hdspi_pkg::CSR_CPHA:      cpha_ff      <= csr_wdata[0];
            hdspi_pkg::CSR_LSB:       lsb_ff       <= csr_wdata[0];
            hdspi_pkg::CSR_CS:        cs_ff        <= csr_wdata[1:0];
            hdspi_pkg::CSR_CMD_BITS:  cmd_bits_ff  <= csr_wdata[5:0];
            hdspi_pkg::CSR_MOSI_BITS: mosi_bits_ff <= csr_wdata[8:0];
            hdspi_pkg::CSR_MISO_BITS: miso_bits_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // saturated phase lengths
   logic [BW-1:0] len_cmd, len_mosi, len_miso;
   always_comb begin
      len_cmd  = (cmd_bits_ff > 6'd32) ? BW'(32) : BW'(cmd_bits_ff);
      len_mosi = (BW'(mosi_bits_ff) > BW'(LIM)) ? BW'(LIM) : BW'(mosi_bits_ff);
      len_miso = (BW'(miso_bits_ff) > BW'(LIM)) ? BW'(LIM) : BW'(miso_bits_ff);
   end

   // engine state
   logic [31:0]   cmd_word_ff, cmd_word_in;
   logic [31:0]   data_mem [DATA_WORDS];
   logic          busy_ff, busy_in;
   logic [1:0]    phase_ff, phase_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [12:0]   tick_ff, tick_in;
   logic          sclk_ff, sclk_in, mosi_ff, mosi_in;

   logic          acc;
   logic [1:0]    rtype;
   logic [3:0]    widx;
   logic [31:0]   wdata;
   logic          miso;
   assign rtype = req_tuser;
   assign widx  = req_tdata[3:0];
   assign wdata = req_tdata[35:4];
   assign miso  = req_tdata[36];

   // output bit for a given phase and bit position
   function automatic logic out_bit_f(input logic [1:0] ph, input logic [BW-1:0] b,
         input logic [BW-1:0] n, input logic [31:0] cw, input logic [31:0] dw,
         input logic lsb);
      logic [4:0] sh;
      logic       r;
      begin
         r = 1'b0;
         sh = '0;
         if (b < n) begin
            if (ph == hdspi_pkg::PH_CMD) begin
               r = cw[5'(n - 1'b1 - b)];
            end else if (ph == hdspi_pkg::PH_MOSI) begin
               sh = {b[4:3], (lsb ? b[2:0] : 3'd7 - b[2:0])};
               r = dw[sh];
            end
         end
         out_bit_f = r;
      end
   endfunction

   logic [BW-1:0] cur_len, nxt_len;
   logic [1:0]    nxt_ph, first_ph;
   logic [WW-1:0] bword;
   logic [31:0]   bdata;
   logic [4:0]    bsh;
   logic [12:0]   period, half;
   logic          cap_en, wr_en;
   logic [WW-1:0] wr_word;
   logic [31:0]   wr_val;
   logic [31:0]   rdata_in;
   logic          rej_in;

   function automatic logic [BW-1:0] plen(input logic [1:0] ph, input logic [BW-1:0] a,
         input logic [BW-1:0] b, input logic [BW-1:0] c);
      begin
         unique case (ph)
            hdspi_pkg::PH_CMD:  plen = a;
            hdspi_pkg::PH_MOSI: plen = b;
            hdspi_pkg::PH_MISO: plen = c;
            default:            plen = '0;
         endcase
      end
   endfunction

   always_comb begin
      cur_len = plen(phase_ff, len_cmd, len_mosi, len_miso);
      first_ph = (len_cmd != 0) ? hdspi_pkg::PH_CMD :
                 (len_mosi != 0) ? hdspi_pkg::PH_MOSI :
                 (len_miso != 0) ? hdspi_pkg::PH_MISO : hdspi_pkg::PH_IDLE;
      if (phase_ff == hdspi_pkg::PH_CMD)
         nxt_ph = (len_mosi != 0) ? hdspi_pkg::PH_MOSI :
                  (len_miso != 0) ? hdspi_pkg::PH_MISO : hdspi_pkg::PH_IDLE;
      else if (phase_ff == hdspi_pkg::PH_MOSI)
         nxt_ph = (len_miso != 0) ? hdspi_pkg::PH_MISO : hdspi_pkg::PH_IDLE;
      else
         nxt_ph = hdspi_pkg::PH_IDLE;
      period = 13'(clk_div_ff) + 13'd2;
      half   = period >> 1;
      bword  = WW'(bit_ff >> 5);
      bdata  = data_mem[bword];
      bsh    = {bit_ff[4:3], (lsb_ff ? bit_ff[2:0] : 3'd7 - bit_ff[2:0])};
      nxt_len = '0;

      cmd_word_in = cmd_word_ff;
      busy_in = busy_ff; phase_in = phase_ff; bit_in = bit_ff;
      tick_in = tick_ff; sclk_in = sclk_ff; mosi_in = mosi_ff;
      cap_en = 1'b0; wr_en = 1'b0; wr_word = bword; wr_val = wdata;
      rdata_in = '0; rej_in = 1'b0;

      if (rtype == hdspi_pkg::REQ_TICK) begin
         if (busy_ff) begin
            if (tick_ff != 13'h1fff) tick_in = tick_ff + 13'd1;
            if (!sclk_ff) begin
               if (tick_in >= half) begin
                  sclk_in = 1'b1;
                  if (!cpha_ff) cap_en = 1'b1;
                  else mosi_in = out_bit_f(phase_ff, bit_ff, cur_len, cmd_word_ff,
                                           bdata, lsb_ff);
               end
            end else if (tick_in >= period) begin
               sclk_in = 1'b0;
               if (cpha_ff) cap_en = 1'b1;
               tick_in = '0;
               bit_in = bit_ff + 1'b1;
               if (bit_in >= cur_len) begin
                  if (nxt_ph == hdspi_pkg::PH_IDLE) begin
                     busy_in = 1'b0; phase_in = hdspi_pkg::PH_IDLE; bit_in = '0;
                     sclk_in = 1'b0; mosi_in = 1'b0;
                  end else begin
                     phase_in = nxt_ph;
                     bit_in = '0;
                  end
               end
               if (busy_in) begin
                  nxt_len = plen(phase_in, len_cmd, len_mosi, len_miso);
                  if (!cpha_ff)
                     mosi_in = out_bit_f(phase_in, bit_in, nxt_len, cmd_word_ff,
                                         data_mem[WW'(bit_in >> 5)], lsb_ff);
                  else if (phase_in == hdspi_pkg::PH_MISO)
                     mosi_in = 1'b0;
               end
            end
            if (cap_en && phase_ff == hdspi_pkg::PH_MISO && bit_ff < len_miso) begin
               wr_en = 1'b1;
               wr_val = bdata;
               wr_val[bsh] = miso;
            end
         end
      end else if (busy_ff) begin
         rej_in = 1'b1;
      end else begin
         unique case (rtype)
            hdspi_pkg::REQ_WRITE: begin
               if (widx == 4'd0) cmd_word_in = wdata;
               else if (5'(widx) <= 5'(DATA_WORDS)) begin
                  wr_en = 1'b1;
                  wr_word = WW'(widx - 4'd1);
               end
            end
            hdspi_pkg::REQ_READ: begin
               if (widx == 4'd0) rdata_in = cmd_word_ff;
               else if (5'(widx) <= 5'(DATA_WORDS)) rdata_in = data_mem[WW'(widx - 4'd1)];
            end
            default: begin
               if (first_ph != hdspi_pkg::PH_IDLE) begin
                  busy_in = 1'b1; phase_in = first_ph; bit_in = '0; tick_in = '0;
                  sclk_in = 1'b0;
                  nxt_len = plen(first_ph, len_cmd, len_mosi, len_miso);
                  mosi_in = cpha_ff ? 1'b0 :
                            out_bit_f(first_ph, '0, nxt_len, cmd_word_ff,
                                      data_mem[0], lsb_ff);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (acc && wr_en) data_mem[wr_word] <= wr_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_word_ff <= '0; busy_ff <= 1'b0; phase_ff <= hdspi_pkg::PH_IDLE;
         bit_ff <= '0; tick_ff <= '0; sclk_ff <= 1'b0; mosi_ff <= 1'b0;
      end else if (acc) begin
         cmd_word_ff <= cmd_word_in; busy_ff <= busy_in; phase_ff <= phase_in;
         bit_ff <= bit_in; tick_ff <= tick_in; sclk_ff <= sclk_in; mosi_ff <= mosi_in;
      end
   end

   // result register with one skid slot
   logic [1:0] cs_n;
   logic [39:0] res;
   always_comb begin
      for (int i = 0; i < 2; i++)
         cs_n[i] = (i < CS_LINES) ? ~cs_ff[i] : 1'b0;
      res = {2'b0, cs_n, mosi_in, cpol_ff ^ sclk_in, rej_in, busy_in, rdata_in};
   end

   logic        v0_ff, v1_ff;
   logic [39:0] d0_ff, d1_ff;
   assign req_tready = !v1_ff;
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = v0_ff;
   assign rsp_tdata = d0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0;
      end else begin
         priority if (!v0_ff || rsp_tready) begin
            if (v1_ff) begin
               v0_ff <= 1'b1; d0_ff <= d1_ff; v1_ff <= acc;
               if (acc) d1_ff <= res;
            end else begin
               v0_ff <= acc;
               if (acc) d0_ff <= res;
            end
         end else if (acc) begin
            v1_ff <= 1'b1; d1_ff <= res;
         end
      end
   end
endmodule
`default_nettype wire
